// ===== src/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared codes for the magic/length/Fletcher-16 deframer: result events and
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

  localparam int EventW    = 2;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  typedef logic [EventW-1:0]    event_t;
  typedef logic [CfgIndexW-1:0] cfg_index_t;

  localparam event_t EV_PAYLOAD   = 2'd0;
  localparam event_t EV_FRAME_OK  = 2'd1;
  localparam event_t EV_FRAME_BAD = 2'd2;

  localparam cfg_index_t CFG_ENABLE     = 2'd0;
  localparam cfg_index_t CFG_MAGIC_WORD = 2'd1;
  localparam cfg_index_t CFG_MAX_LENGTH = 2'd2;

  localparam logic [8:0] FletcherMod = 9'd255;

endpackage

`default_nettype wire

// ===== src/magic_length_fletcher_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// magic_length_fletcher_deframer_unit
// Hunts for a two-byte sync word, reads a big-endian length, passes payload
// bytes out while running a Fletcher-16 sum, then reports the checksum result.
// ----------------------------------------------------------------------------
// Each result beat is registered and shows in the cycle after its byte is accepted.
// Throughput: one byte per cycle; in_ready drops only while a result beat
//   waits in the output register and out_ready is low.
// Bytes that give no result (sync, length, first checksum byte) are consumed
//   with no beat out. Reset (rst, synchronous) returns to the sync hunt,
//   clears the sums and loads enable = 0, magic_word = 0, max_length = 256.
`default_nettype none

module magic_length_fletcher_deframer_unit #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire mlfd_pkg::cfg_index_t      cfg_index,
  input  wire logic [15:0]               cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mlfd_pkg::event_t               event_res,
  output logic [7:0]                     payload_byte,
  output logic [8:0]                     frame_length,
  output logic [15:0]                    got_checksum
);

  import mlfd_pkg::*;

  localparam logic [16:0] PayloadCap = 17'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    SYNC_HI, SYNC_LO, LEN_HI, LEN_LO, PAYLOAD, CK_HI, CK_LO
  } phase_t;

  phase_t      phase, phase_next;
  logic        enable;
  logic [15:0] magic_word;
  logic [8:0]  max_length;
  logic [7:0]  length_high, length_high_next;
  logic [8:0]  payload_length, payload_length_next;
  logic [8:0]  payload_count, payload_count_next;
  logic [7:0]  sum_low, sum_low_next;
  logic [7:0]  sum_high, sum_high_next;
  logic [7:0]  checksum_high_byte, checksum_high_byte_next;

  logic        in_beat;
  logic        emit;
  event_t      ev;
  logic [7:0]  pb;
  logic [15:0] cs;

  logic [8:0]  lo_add, lo_mod, hi_add, hi_mod;
  logic [15:0] len_word;
  logic [16:0] limit;
  logic        too_long;
  logic [15:0] got_word;

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Both halves stay below 255, so one conditional subtract does the mod
  assign lo_add = {1'b0, sum_low} + {1'b0, rx_byte};
  assign lo_mod = (lo_add >= FletcherMod) ? lo_add - FletcherMod : lo_add;
  assign hi_add = {1'b0, sum_high} + lo_mod;
  assign hi_mod = (hi_add >= FletcherMod) ? hi_add - FletcherMod : hi_add;

  assign len_word = {length_high, rx_byte};
  assign limit    = ({8'd0, max_length} > PayloadCap) ? PayloadCap : {8'd0, max_length};
  assign too_long = {1'b0, len_word} > limit;
  assign got_word = {checksum_high_byte, rx_byte};

  always_comb begin
    phase_next              = phase;
    length_high_next        = length_high;
    payload_length_next     = payload_length;
    payload_count_next      = payload_count;
    sum_low_next            = sum_low;
    sum_high_next           = sum_high;
    checksum_high_byte_next = checksum_high_byte;
    emit                    = 1'b0;
    ev                      = EV_PAYLOAD;
    pb                      = 8'd0;
    cs                      = 16'd0;
    if (enable) begin
      case (phase)
        SYNC_HI: begin
          if (rx_byte == magic_word[15:8]) phase_next = SYNC_LO;
        end
        SYNC_LO: begin
          if (rx_byte == magic_word[7:0]) phase_next = LEN_HI;
          else if (rx_byte == magic_word[15:8]) phase_next = SYNC_LO;
          else phase_next = SYNC_HI;
        end
        LEN_HI: begin
          length_high_next = rx_byte;
          phase_next       = LEN_LO;
        end
        LEN_LO: begin
          if (too_long) begin
            phase_next = SYNC_HI;
          end else begin
            // limit never exceeds 511, so the low nine bits hold the length
            payload_length_next = len_word[8:0];
            payload_count_next  = 9'd0;
            sum_low_next        = 8'd0;
            sum_high_next       = 8'd0;
            phase_next          = (len_word == 16'd0) ? CK_HI : PAYLOAD;
          end
        end
        PAYLOAD: begin
          sum_low_next       = lo_mod[7:0];
          sum_high_next      = hi_mod[7:0];
          payload_count_next = payload_count + 9'd1;
          if (payload_count + 9'd1 == payload_length) phase_next = CK_HI;
          emit = 1'b1;
          ev   = EV_PAYLOAD;
          pb   = rx_byte;
        end
        CK_HI: begin
          checksum_high_byte_next = rx_byte;
          phase_next              = CK_LO;
        end
        CK_LO: begin
          phase_next = SYNC_HI;
          emit       = 1'b1;
          ev         = (got_word == {sum_high, sum_low}) ? EV_FRAME_OK : EV_FRAME_BAD;
          cs         = got_word;
        end
        default: begin
          phase_next = SYNC_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= SYNC_HI;
      enable             <= 1'b0;
      magic_word         <= 16'd0;
      max_length         <= 9'd256;
      length_high        <= 8'd0;
      payload_length     <= 9'd0;
      payload_count      <= 9'd0;
      sum_low            <= 8'd0;
      sum_high           <= 8'd0;
      checksum_high_byte <= 8'd0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ENABLE:     enable     <= cfg_data[0];
          CFG_MAGIC_WORD: magic_word <= cfg_data;
          CFG_MAX_LENGTH: max_length <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        phase              <= phase_next;
        length_high        <= length_high_next;
        payload_length     <= payload_length_next;
        payload_count      <= payload_count_next;
        sum_low            <= sum_low_next;
        sum_high           <= sum_high_next;
        checksum_high_byte <= checksum_high_byte_next;
        out_valid          <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; frame_length follows the length in force for this beat
  always_ff @(posedge clk) begin
    if (in_beat && emit) begin
      event_res    <= ev;
      payload_byte <= pb;
      frame_length <= payload_length_next;
      got_checksum <= cs;
    end
  end

  a_no_reserved_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EV_PAYLOAD || event_res == EV_FRAME_OK ||
                   event_res == EV_FRAME_BAD))
    else $error("reserved event code on output");

  a_payload_no_checksum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_PAYLOAD) |-> (got_checksum == 16'd0))
    else $error("payload beat carries a checksum");

  a_frame_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_PAYLOAD) |-> (payload_byte == 8'd0))
    else $error("frame end beat carries a payload byte");

  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    (!enable && !cfg_write) |=> $stable(phase) && $stable(sum_low) && $stable(sum_high))
    else $error("state moved while disabled");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PAYLOAD) |-> (payload_count < payload_length))
    else $error("payload count overran the frame length");

endmodule

`default_nettype wire
